[hw/rtl/mtes_pkg.sv]
// Package: shared types and constants for the timer expiry scheduler.
package mtes_pkg;
  localparam int unsigned Timers = 16;
  localparam int unsigned IdW = 4;
  localparam logic [31:0] HalfRange = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_SET    = 3'd1,
    FN_START  = 3'd2,
    FN_STOP   = 3'd3,
    FN_DETACH = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_SCAN,
    ST_PICK,
    ST_EMIT,
    ST_NONE,
    ST_OUT
  } state_e;

  // One timer entry as held in memory.
  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] period;
    logic        mode;
    logic [31:0] rank;
  } entry_t;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic           we;
    logic [IdW-1:0] waddr;
    entry_t         wdata;
    logic [IdW-1:0] raddr;
  } mem_req_t;
endpackage

[hw/rtl/mtes_mem.sv]
// Timer entry memory: one write port, one registered read port.
module mtes_mem (
  input  logic               clk_i,
  input  mtes_pkg::mem_req_t req_i,
  output mtes_pkg::entry_t   rdata_o
);
  mtes_pkg::entry_t mem_q [mtes_pkg::Timers];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule

[hw/rtl/multi_timer_expiry_scheduler_unit.sv]
// Top level: timer table with an entry memory and a scan sequencer.
// A non-tick result is registered in the op state; input is refused until that result is taken.
// A tick scans all 16 entries per report: a scan, a pick and an emit for each fired timer,
// plus a closing scan and pick (none after the sixteenth report).
// Input stalls while a transaction runs or a result waits; the read port sets the scan time.
// Reset clears the tick, start counter and active marks; entry data stays undefined.
module multi_timer_expiry_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [3:0]  timer_id_i,
  input  logic [31:0] period_ticks_i,
  input  logic        periodic_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        fired_o,
  output logic [3:0]  fired_timer_o,
  output logic [31:0] now_ticks_o,
  output logic        last_o
);
  localparam int unsigned IdW = mtes_pkg::IdW;

  mtes_pkg::state_e state_q, state_d;
  logic [31:0] now_q, now_d, cnt_q, cnt_d;
  logic [mtes_pkg::Timers-1:0] act_q, act_d, due_q, due_d;
  logic [2:0] fn_q;
  logic [IdW-1:0] id_q;
  logic [31:0] per_q;
  logic mode_q;
  // scan: issue address scan_q, data arrives for rd_q
  logic [IdW:0] scan_q, scan_d;
  logic [IdW-1:0] rd_q, rd_d;
  logic rdv_q, rdv_d;
  logic have_q, have_d;
  logic [IdW-1:0] best_q, best_d;
  logic [31:0] bage_q, bage_d, brank_q, brank_d;
  logic [31:0] pper_q, pper_d;
  logic pmode_q, pmode_d;
  logic [4:0] nfired_q, nfired_d;
  logic first_q, first_d;
  // result register
  logic ov_q, ov_d, st_q, st_d, fr_q, fr_d, ls_q, ls_d;
  logic [IdW-1:0] ft_q, ft_d;
  logic in_take;

  mtes_pkg::mem_req_t req;
  mtes_pkg::entry_t rdata;

  mtes_mem u_mem (.clk_i(clk_i), .req_i(req), .rdata_o(rdata));

  // hold the input while busy or while a result still waits to be taken
  assign in_stall_o = (state_q != mtes_pkg::ST_IDLE) || ov_q;
  assign in_take    = in_valid_i && !in_stall_o;

  logic [31:0] age_r, rage_r;
  logic cand, better;
  always_comb begin
    age_r  = now_q - rdata.deadline;
    rage_r = cnt_q - rdata.rank;
    cand   = rdv_q && due_q[rd_q];
    better = !have_q || (age_r > bage_q) || (age_r == bage_q && rage_r > brank_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtes_pkg::ST_IDLE: if (in_take) begin
        state_d = (func_i == mtes_pkg::FN_TICK) ? mtes_pkg::ST_SCAN : mtes_pkg::ST_OP;
      end
      mtes_pkg::ST_OP:   state_d = mtes_pkg::ST_OUT;
      mtes_pkg::ST_SCAN: if (!rdv_q && scan_q == (IdW+1)'(mtes_pkg::Timers)) begin
        state_d = mtes_pkg::ST_PICK;
      end
      mtes_pkg::ST_PICK: state_d = have_q ? mtes_pkg::ST_EMIT
                               : (nfired_q == '0 ? mtes_pkg::ST_NONE : mtes_pkg::ST_IDLE);
      mtes_pkg::ST_EMIT: if (!ov_q || !out_stall_i) begin
        state_d = (nfired_q == 5'd15) ? mtes_pkg::ST_IDLE : mtes_pkg::ST_SCAN;
      end
      mtes_pkg::ST_NONE: if (!ov_q || !out_stall_i) state_d = mtes_pkg::ST_IDLE;
      mtes_pkg::ST_OUT:  if (!ov_q || !out_stall_i) state_d = mtes_pkg::ST_IDLE;
      default: state_d = mtes_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    now_d = now_q; cnt_d = cnt_q; act_d = act_q; due_d = due_q;
    scan_d = scan_q; rd_d = rd_q; rdv_d = 1'b0;
    have_d = have_q; best_d = best_q; bage_d = bage_q; brank_d = brank_q;
    pper_d = pper_q; pmode_d = pmode_q; nfired_d = nfired_q; first_d = first_q;
    ov_d = ov_q && out_stall_i; st_d = st_q; fr_d = fr_q; ls_d = ls_q; ft_d = ft_q;
    req = '0;
    req.raddr = scan_q[IdW-1:0];
    case (state_q)
      mtes_pkg::ST_IDLE: if (in_take && func_i == mtes_pkg::FN_TICK) begin
        now_d = now_q + 32'd1; scan_d = '0; have_d = 1'b0; nfired_d = '0;
        first_d = 1'b1;
      end
      mtes_pkg::ST_OP: begin
        st_d = 1'b0;
        case (fn_q)
          mtes_pkg::FN_SET: begin
            req.we = 1'b1; req.waddr = id_q;
            req.wdata.deadline = '0; req.wdata.period = per_q;
            req.wdata.mode = mode_q; req.wdata.rank = '0;
            act_d[id_q] = 1'b0;
          end
          mtes_pkg::FN_START: begin
            // read-modify-write: rdata holds this entry (raddr issued at accept)
            req.we = 1'b1; req.waddr = id_q;
            req.wdata.deadline = now_q + rdata.period; req.wdata.period = rdata.period;
            req.wdata.mode = rdata.mode; req.wdata.rank = cnt_q;
            cnt_d = cnt_q + 32'd1; act_d[id_q] = 1'b1;
          end
          mtes_pkg::FN_STOP: begin
            st_d = !act_q[id_q]; act_d[id_q] = 1'b0;
          end
          mtes_pkg::FN_DETACH: act_d[id_q] = 1'b0;
          default: ;
        endcase
        ov_d = 1'b1; fr_d = 1'b0; ft_d = '0; ls_d = 1'b1;
      end
      mtes_pkg::ST_SCAN: begin
        if (scan_q != (IdW+1)'(mtes_pkg::Timers)) begin
          rdv_d = 1'b1; rd_d = scan_q[IdW-1:0]; scan_d = scan_q + 1'b1;
        end
        if (rdv_q) begin
          if (first_q) due_d[rd_q] = act_q[rd_q] && (age_r < mtes_pkg::HalfRange);
          if ((first_q ? (act_q[rd_q] && age_r < mtes_pkg::HalfRange) : cand) && better) begin
            have_d = 1'b1; best_d = rd_q; bage_d = age_r; brank_d = rage_r;
            pper_d = rdata.period; pmode_d = rdata.mode;
          end
        end
      end
      mtes_pkg::ST_PICK: begin
        first_d = 1'b0;
        // with no due timer left the tick ends; a none result follows only if nothing fired
      end
      mtes_pkg::ST_EMIT: if (!ov_q || !out_stall_i) begin
        due_d[best_q] = 1'b0;
        if (pmode_q) begin
          req.we = 1'b1; req.waddr = best_q;
          req.wdata.deadline = now_q + pper_q; req.wdata.period = pper_q;
          req.wdata.mode = 1'b1; req.wdata.rank = cnt_q;
          cnt_d = cnt_q + 32'd1;
        end else begin
          act_d[best_q] = 1'b0;
        end
        ov_d = 1'b1; st_d = 1'b0; fr_d = 1'b1; ft_d = best_q;
        ls_d = (nfired_q == 5'd15) || ((due_q & ~({{(mtes_pkg::Timers-1){1'b0}}, 1'b1}
               << best_q)) == '0);
        nfired_d = nfired_q + 5'd1; scan_d = '0; have_d = 1'b0;
      end
      mtes_pkg::ST_NONE: if (!ov_q || !out_stall_i) begin
        ov_d = 1'b1; st_d = 1'b0; fr_d = 1'b0; ft_d = '0; ls_d = 1'b1;
      end
      default: ;
    endcase
    if (state_q == mtes_pkg::ST_IDLE) req.raddr = timer_id_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtes_pkg::ST_IDLE; now_q <= '0; cnt_q <= '0; act_q <= '0;
      ov_q <= 1'b0; rdv_q <= 1'b0; have_q <= 1'b0; nfired_q <= '0; first_q <= 1'b0;
      scan_q <= '0; due_q <= '0;
    end else begin
      state_q <= state_d; now_q <= now_d; cnt_q <= cnt_d; act_q <= act_d;
      ov_q <= ov_d; rdv_q <= rdv_d; have_q <= have_d; nfired_q <= nfired_d;
      first_q <= first_d; scan_q <= scan_d; due_q <= due_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      fn_q <= func_i; id_q <= timer_id_i; per_q <= period_ticks_i; mode_q <= periodic_i;
    end
    rd_q <= rd_d; best_q <= best_d; bage_q <= bage_d; brank_q <= brank_d;
    pper_q <= pper_d; pmode_q <= pmode_d;
    st_q <= st_d; fr_q <= fr_d; ls_q <= ls_d; ft_q <= ft_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign fired_o       = fr_q;
  assign fired_timer_o = ft_q;
  assign now_ticks_o   = now_q;
  assign last_o        = ls_q;

`ifndef NO_ASSERTIONS
  a_fire_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtes_pkg::ST_EMIT && (!ov_q || !out_stall_i)) |=> !due_q[$past(best_q)])
    else $error("fired timer still due");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mtes_pkg::ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");
  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && func_i == mtes_pkg::FN_TICK)
    |=> now_q == $past(now_q) + 32'd1)
    else $error("tick did not advance");
`endif
endmodule
